FILE: src/bsr_pkg.sv
`timescale 1ns / 1ps
package bsr_pkg;
	localparam int CAPACITY = 64;
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic [31:0] seg_start;
		logic [31:0] seg_length;
		logic [31:0] byte_pos;
		logic [7:0]  data_byte;
		logic        byte_valid;
		logic        last_of_segment;
		logic        eof_flag;
		logic [6:0]  out_space;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       last_of_run;
		logic       stream_ended;
		logic [6:0] unassembled_count;
	} res_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic scan_step;
		logic scan_end;
		logic emit;
		logic status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_last;
		logic scan_more;
		logic cnt_zero;
		logic rem_last;
		logic out_free;
	} sts_t;
endpackage

FILE: src/bsr_ctrl.sv
`timescale 1ns / 1ps
module bsr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bsr_pkg::sts_t sts,
	output bsr_pkg::cmd_t cmd
);
	import bsr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_STAT = 3'd5;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.is_last ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (sts.scan_more) begin
					cmd.scan_step = 1'b1;
				end else begin
					cmd.scan_end = 1'b1;
					state_d      = sts.cnt_zero ? ST_STAT : ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.rem_last ? ST_IDLE : ST_RD;
				end
			end
			ST_STAT: begin
				if (sts.out_free) begin
					cmd.status = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

FILE: src/bsr_datapath.sv
`timescale 1ns / 1ps
module bsr_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  bsr_pkg::in_item_t  in_item,
	input  bsr_pkg::cmd_t      cmd,
	output bsr_pkg::sts_t      sts,
	input  logic               res_ready,
	output logic               res_valid,
	output bsr_pkg::res_item_t res_item
);
	import bsr_pkg::*;

	in_item_t       item_q;
	logic [7:0]     mem [CAPACITY];
	logic [7:0]     rd_q;
	logic [CAPACITY-1:0] valid_q;
	logic [IW-1:0]  head_q, scan_q;
	logic [31:0]    next_q;
	logic [CW-1:0]  held_q, cnt_q, rem_q;
	logic           eof_q, ended_q;
	logic           res_valid_q;
	res_item_t      res_q;

	logic [CW-1:0]  space;
	logic [32:0]    wend, abs_i, seg_end;
	logic [IW-1:0]  off;
	logic [IW:0]    slot_sum;
	logic [IW-1:0]  slot;
	logic           in_win, do_store, do_eof;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
		return (v == IW'(CAPACITY - 1)) ? '0 : v + 1'b1;
	endfunction

	// window and slot for the held item
	always_comb begin
		space    = (item_q.out_space > 7'(CAPACITY)) ? CW'(CAPACITY) : CW'(item_q.out_space);
		wend     = {1'b0, next_q} + 33'(space);
		abs_i    = {1'b0, item_q.seg_start} + {1'b0, item_q.byte_pos};
		seg_end  = {1'b0, item_q.seg_start} + {1'b0, item_q.seg_length};
		in_win   = {1'b0, item_q.seg_start} < wend;
		off      = IW'(abs_i - {1'b0, next_q});
		slot_sum = {1'b0, head_q} + {1'b0, off};
		slot     = (slot_sum >= (IW+1)'(CAPACITY)) ? IW'(slot_sum - (IW+1)'(CAPACITY))
			: slot_sum[IW-1:0];
		do_store = in_win && item_q.byte_valid && (item_q.byte_pos < item_q.seg_length)
			&& (abs_i >= {1'b0, next_q}) && (abs_i < wend) && !valid_q[slot];
		do_eof   = in_win && item_q.last_of_segment && item_q.eof_flag && (seg_end <= wend);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.eval && do_store) mem[slot] <= item_q.data_byte;
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			head_q      <= '0;
			scan_q      <= '0;
			next_q      <= '0;
			held_q      <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
			eof_q       <= 1'b0;
			ended_q     <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cmd.emit || cmd.status) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			if (cmd.eval) begin
				if (do_store) begin
					valid_q[slot] <= 1'b1;
					held_q        <= held_q + 1'b1;
				end
				if (do_eof) eof_q <= 1'b1;
				scan_q <= head_q;
				cnt_q  <= '0;
			end
			if (cmd.scan_step) begin
				scan_q <= wrap_inc(scan_q);
				cnt_q  <= cnt_q + 1'b1;
			end
			if (cmd.scan_end) begin
				held_q  <= held_q - cnt_q;
				rem_q   <= cnt_q;
				ended_q <= eof_q && (held_q == cnt_q);
			end
			if (cmd.emit) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= wrap_inc(head_q);
				next_q          <= next_q + 32'd1;
				rem_q           <= rem_q - 1'b1;
				res_q.out_byte  <= rd_q;
				res_q.out_valid <= 1'b1;
				res_q.last_of_run <= (rem_q == CW'(1));
				res_q.stream_ended <= ended_q;
				res_q.unassembled_count <= 7'(held_q);
			end
			if (cmd.status) begin
				res_q.out_byte  <= '0;
				res_q.out_valid <= 1'b0;
				res_q.last_of_run <= 1'b1;
				res_q.stream_ended <= ended_q;
				res_q.unassembled_count <= 7'(held_q);
			end
		end
	end

	always_comb begin
		sts.is_last   = item_q.last_of_segment;
		sts.scan_more = (cnt_q < CW'(CAPACITY)) && valid_q[scan_q];
		sts.cnt_zero  = (cnt_q == '0);
		sts.rem_last  = (rem_q == CW'(1));
		sts.out_free  = !res_valid_q || res_ready;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;
endmodule

FILE: src/byte_stream_reassembler_unit.sv
`timescale 1ns / 1ps
// byte stream reassembler: takes one segment byte per input transfer and
// stores it in a 64-entry ring if it falls inside the window next_expected
// .. next_expected + min(out_space, 64). an input transfer that is not the
// last of its segment is evaluated and gives no result. the last one is
// evaluated, then the contiguous held bytes from the ring head are scanned,
// then the run goes out byte by byte (ring memory read, then output
// register, waiting while the output is stalled); with nothing to deliver
// a single status result goes out. a new input transfer is taken once the
// run is handed to the output register. every result carries the held
// count and end-of-stream flag as they stand after the whole run.
module byte_stream_reassembler_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bsr_pkg::in_item_t  in_item,
	output logic               res_valid,
	input  logic               res_ready,
	output bsr_pkg::res_item_t res_item
);
	import bsr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing of capture, evaluate, scan, emit and status
	bsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ring store, window math and output register
	bsr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res_item  (res_item)
	);
endmodule

FILE: src/bsr_checker.sv
`timescale 1ns / 1ps
module bsr_sva (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input bsr_pkg::res_item_t res_item
);
	import bsr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.out_valid |-> res_item.last_of_run)
		else $error("status result not last of run");

	a_ended: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.stream_ended |-> res_item.unassembled_count == 7'd0)
		else $error("stream ended with held bytes");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.unassembled_count <= 7'(CAPACITY))
		else $error("held count above capacity");
endmodule

bind byte_stream_reassembler_unit bsr_sva u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_item  (res_item)
);

FILE: dv/bsr_checker.sv
`timescale 1ns / 1ps
module bsr_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  bsr_pkg::in_item_t  in_item,
	input  logic               res_valid,
	input  logic               res_ready,
	input  bsr_pkg::res_item_t res_item,
	output int                 fail_count,
	output int                 pending
);
	import bsr_pkg::*;

	localparam int EXP_DEPTH = 1024;

	logic [7:0]  ring_data [CAPACITY];
	logic        ring_held [CAPACITY];
	logic [5:0]  head;
	logic [31:0] expected_idx;
	int          held;
	logic        eof_latched;
	res_item_t   exp_buf [EXP_DEPTH];
	int          wr_total;
	int          rd_total;

	assign pending = wr_total - rd_total;

	task automatic reassemble(input in_item_t it);
		logic [32:0] win_end;
		logic [32:0] abs_idx;
		logic [6:0]  space;
		logic [5:0]  slot;
		int          n;
		res_item_t   run [CAPACITY];
		space = (it.out_space > 7'(CAPACITY)) ? 7'(CAPACITY) : it.out_space;
		win_end = {1'b0, expected_idx} + 33'(space);
		if ({1'b0, it.seg_start} < win_end) begin
			abs_idx = {1'b0, it.seg_start} + {1'b0, it.byte_pos};
			if (it.byte_valid && it.byte_pos < it.seg_length
					&& abs_idx >= {1'b0, expected_idx} && abs_idx < win_end) begin
				slot = head + 6'(abs_idx - {1'b0, expected_idx});
				if (!ring_held[slot]) begin
					ring_data[slot] = it.data_byte;
					ring_held[slot] = 1'b1;
					held++;
				end
			end
			if (it.last_of_segment && it.eof_flag
					&& ({1'b0, it.seg_start} + {1'b0, it.seg_length}) <= win_end)
				eof_latched = 1'b1;
		end
		if (!it.last_of_segment)
			return;
		n = 0;
		while (n < CAPACITY && ring_held[head]) begin
			run[n] = '0;
			run[n].out_byte = ring_data[head];
			run[n].out_valid = 1'b1;
			ring_held[head] = 1'b0;
			head++;
			expected_idx++;
			if (held > 0)
				held--;
			n++;
		end
		if (n == 0) begin
			run[0] = '0;
			n = 1;
		end
		for (int k = 0; k < n; k++) begin
			run[k].last_of_run = (k == n - 1);
			run[k].stream_ended = eof_latched && held == 0;
			run[k].unassembled_count = 7'(held);
			exp_buf[wr_total[9:0]] = run[k];
			wr_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_item_t e;
		if (!arst_n) begin
			foreach (ring_held[i])
				ring_held[i] = 1'b0;
			head = '0;
			expected_idx = '0;
			held = 0;
			eof_latched = 1'b0;
			fail_count <= 0;
			wr_total = 0;
			rd_total = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (pending == 0) begin
					if (fail_count < 10)
						$display("unexpected result %p", res_item);
					fail_count <= fail_count + 1;
				end else begin
					e = exp_buf[rd_total[9:0]];
					rd_total++;
					if (e !== res_item) begin
						if (fail_count < 10)
							$display("mismatch: expected %p got %p", e, res_item);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				reassemble(in_item);
		end
	end
endmodule

FILE: dv/tb_byte_stream_reassembler_unit.sv
`timescale 1ns / 1ps
module tb_byte_stream_reassembler_unit;
	import bsr_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_item_t res_item;
	int        fail_count;
	int        pending;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        sent;
	logic [31:0] stream_pos;

	always #1 clk = ~clk;

	byte_stream_reassembler_unit uut (.*);

	bsr_checker chk (.*);

	// receiver stalls at random, weighted by the current phase
	always @(posedge clk)
		res_ready <= ($urandom_range(99) >= recv_idle_pct);

	// one transfer, with random idle cycles ahead of it
	task automatic put(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// send a whole segment in random byte order, last item carries the flag
	task automatic segment(input logic [31:0] start, input int len, input logic eof,
			input logic [6:0] space);
		in_item_t it;
		int       order [128];
		int       j;
		int       tmp;
		for (int i = 0; i < len; i++)
			order[i] = i;
		for (int i = len - 1; i > 0; i--) begin
			j = int'($urandom_range(i));
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if (len == 0) begin
			it = '0;
			it.seg_start = start;
			it.last_of_segment = 1'b1;
			it.eof_flag = eof;
			it.out_space = space;
			put(it);
			return;
		end
		for (int k = 0; k < len; k++) begin
			it.seg_start = start;
			it.seg_length = 32'(len);
			it.byte_pos = 32'(order[k]);
			it.data_byte = 8'($urandom);
			it.byte_valid = 1'b1;
			it.last_of_segment = (k == len - 1);
			it.eof_flag = eof;
			it.out_space = space;
			put(it);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		// non-last transfers may still be inside the block
		repeat (20) @(posedge clk);
	endtask

	// random item, mostly near the window so bytes are kept
	function automatic in_item_t noise_item();
		in_item_t     it;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		if ($urandom_range(3) != 0) begin
			it.seg_start = stream_pos + $urandom_range(40);
			it.seg_length = $urandom_range(16);
			it.byte_pos = $urandom_range(17);
		end
		it.out_space = 7'($urandom_range(127));
		return it;
	endfunction

	initial begin
		in_item_t it;
		send_idle_pct = 36;
		recv_idle_pct = 73;
		sent = 0;
		stream_pos = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: in-order, out-of-order, overlap, empty, rejected, field extremes
		segment(32'd0, 4, 1'b0, 7'd64);
		segment(32'd8, 3, 1'b0, 7'd127);
		segment(32'd4, 5, 1'b0, 7'd64);
		segment(32'd11, 0, 1'b0, 7'd10);
		segment(32'd200, 1, 1'b1, 7'd64);
		it = '1;
		put(it);
		it = '0;
		it.last_of_segment = 1'b1;
		it.byte_valid = 1'b1;
		it.seg_start = 32'hFFFF_FFFF;
		it.byte_pos = 32'hFFFF_FFFF;
		put(it);
		it.seg_start = 32'd11;
		it.seg_length = 32'd2;
		it.byte_pos = 32'd5;
		put(it);
		segment(32'd11, 2, 1'b0, 7'd0);
		segment(32'd11, 70, 1'b0, 7'd64);
		drain();

		// random phases; the stream position moves on only while no result is pending
		stream_pos = 32'd75;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 73 : 0;
			recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 36 : 0;
			for (int n = 0; n < 114; ) begin
				if ($urandom_range(4) == 0) begin
					put(noise_item());
					n++;
				end else begin
					int len;
					len = int'($urandom_range(12));
					segment(stream_pos + $urandom_range(30), len, ($urandom_range(9) == 0),
						($urandom_range(5) == 0) ? 7'($urandom_range(127)) : 7'd64);
					n += (len == 0) ? 1 : len;
				end
				if (pending == 0 && $urandom_range(3) == 0)
					stream_pos = stream_pos + $urandom_range(20);
			end
		end
		drain();
		if (fail_count == 0)
			$display("tb_byte_stream_reassembler_unit: clean");
		else
			$display("tb_byte_stream_reassembler_unit: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_byte_stream_reassembler_unit: errors");
		$finish;
	end
endmodule
